>>> hw/rtl/pic_pkg.sv
// Package for the eight-line interrupt controller: request codes, command bits and helpers.
`default_nettype none

package pic_pkg;

  // Request kinds carried in the slave tuser
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_ACK   = 2'd2,
    REQ_TICK  = 2'd3
  } req_type_e;

  // Port select
  localparam logic PORT_CMD  = 1'b0;
  localparam logic PORT_DATA = 1'b1;

  // Initialisation sequence position
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_VECTOR  = 2'd1,
    PH_CASCADE = 2'd2,
    PH_MODE    = 2'd3
  } phase_e;

  // Command word bit positions and codes
  localparam int unsigned CmdInitBit = 4;
  localparam int unsigned Ocw3Bit    = 3;
  localparam int unsigned Ocw3RrBit  = 1;
  localparam int unsigned Ocw3RisBit = 0;
  localparam int unsigned InitModeBit = 0;
  localparam int unsigned InitSnglBit = 1;
  localparam logic [2:0] OCW2_NS_EOI = 3'b001;
  localparam logic [2:0] SPURIOUS_LEVEL = 3'd7;

  // Level code that means no bit is set
  localparam logic [3:0] LEVEL_NONE = 4'd8;

  // Index of the lowest set bit, LEVEL_NONE when none is set
  function automatic logic [3:0] lowest_set(input logic [7:0] v);
    logic [3:0] idx;
    idx = LEVEL_NONE;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  // Level that may be delivered now, LEVEL_NONE when none
  function automatic logic [3:0] eligible_level(input logic [7:0] req,
                                                input logic [7:0] mask,
                                                input logic [7:0] svc);
    logic [3:0] lvl;
    logic [3:0] isr;
    lvl = lowest_set(req & ~mask);
    isr = lowest_set(svc);
    return (lvl < isr) ? lvl : LEVEL_NONE;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/programmable_interrupt_controller.sv
// Eight-line priority interrupt controller with a registered result stage.
// Each accepted request's result is registered and shows on m_axis from the edge that accepts it.
// Throughput: one request per cycle; s_axis_tready drops only while a result waits.
// All state and the next result come from one pass of logic over the state registers.
// Reset (rst_ni low, asynchronous) clears the state registers and the valid flag and leaves no result pending.
`default_nettype none

module programmable_interrupt_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] write_data, [15:8] request_lines
  input  wire logic [2:0]  s_axis_tuser,  // [1:0] req_type, [2] port_sel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [7:0] read_data, [15:8] vector, [16] int_pending,
                                          // [17] spurious, [18] initialising, [23:19] zero
);
  import pic_pkg::*;

  // Controller state
  logic [7:0] req_q, req_d;
  logic [7:0] svc_q, svc_d;
  logic [7:0] mask_q, mask_d;
  logic [4:0] vec_up_q, vec_up_d;
  phase_e     phase_q, phase_d;
  logic       mode_exp_q, mode_exp_d;
  logic       single_q, single_d;
  logic [7:0] cascade_q, cascade_d;
  logic       rss_q, rss_d;
  logic [7:0] prev_q, prev_d;

  // Result register
  logic       out_valid_q;
  logic [7:0] rd_q, rd_d;
  logic [7:0] vec_q, vec_d;
  logic       pend_q, pend_d;
  logic       spur_q, spur_d;
  logic       init_q, init_d;

  logic       accept;
  req_type_e  kind;
  logic       port;
  logic [7:0] wdata;
  logic [7:0] lines;
  logic [3:0] ack_lvl;
  logic [7:0] ack_bit;

  assign kind  = req_type_e'(s_axis_tuser[1:0]);
  assign port  = s_axis_tuser[2];
  assign wdata = s_axis_tdata[7:0];
  assign lines = s_axis_tdata[15:8];

  // Take a new request whenever the result slot is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ack_lvl = eligible_level(req_q, mask_q, svc_q);
  assign ack_bit = 8'(1) << ack_lvl[2:0];

  // Next state and result for the request on the slave side
  always_comb begin
    req_d      = req_q;
    svc_d      = svc_q;
    mask_d     = mask_q;
    vec_up_d   = vec_up_q;
    phase_d    = phase_q;
    mode_exp_d = mode_exp_q;
    single_d   = single_q;
    cascade_d  = cascade_q;
    rss_d      = rss_q;
    prev_d     = prev_q;
    rd_d       = 8'd0;
    vec_d      = 8'd0;
    spur_d     = 1'b0;

    unique case (kind)
      REQ_WRITE: begin
        if (port == PORT_CMD) begin
          if (wdata[CmdInitBit]) begin
            mask_d     = 8'd0;
            rss_d      = 1'b0;
            mode_exp_d = wdata[InitModeBit];
            single_d   = wdata[InitSnglBit];
            phase_d    = PH_VECTOR;
          end else if (wdata[Ocw3Bit]) begin
            if (wdata[Ocw3RrBit]) rss_d = wdata[Ocw3RisBit];
          end else if (wdata[7:5] == OCW2_NS_EOI) begin
            // Drop the lowest set in-service bit
            svc_d = svc_q & (svc_q - 8'd1);
          end
        end else begin
          unique case (phase_q)
            PH_VECTOR: begin
              vec_up_d = wdata[7:3];
              if (!single_q)       phase_d = PH_CASCADE;
              else if (mode_exp_q) phase_d = PH_MODE;
              else                 phase_d = PH_IDLE;
            end
            PH_CASCADE: begin
              cascade_d = wdata;
              phase_d   = mode_exp_q ? PH_MODE : PH_IDLE;
            end
            PH_MODE: phase_d = PH_IDLE;
            default: mask_d = wdata;
          endcase
        end
      end
      REQ_READ: begin
        if (port == PORT_CMD) rd_d = rss_q ? svc_q : req_q;
        else                  rd_d = mask_q;
      end
      REQ_ACK: begin
        if (ack_lvl != LEVEL_NONE) begin
          svc_d = svc_q | ack_bit;
          req_d = req_q & ~ack_bit;
          vec_d = {vec_up_q, ack_lvl[2:0]};
        end else begin
          vec_d  = {vec_up_q, SPURIOUS_LEVEL};
          spur_d = 1'b1;
        end
      end
      default: begin
        // Latch rising edges, drop withdrawn lines
        req_d  = (req_q | (lines & ~prev_q)) & lines;
        prev_d = lines;
      end
    endcase

    pend_d = (eligible_level(req_d, mask_d, svc_d) != LEVEL_NONE);
    init_d = (phase_d != PH_IDLE);
  end

  // Hold controller state, advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q      <= 8'd0;
      svc_q      <= 8'd0;
      mask_q     <= 8'd0;
      vec_up_q   <= 5'd0;
      phase_q    <= PH_IDLE;
      mode_exp_q <= 1'b0;
      single_q   <= 1'b0;
      cascade_q  <= 8'd0;
      rss_q      <= 1'b0;
      prev_q     <= 8'd0;
    end else if (accept) begin
      req_q      <= req_d;
      svc_q      <= svc_d;
      mask_q     <= mask_d;
      vec_up_q   <= vec_up_d;
      phase_q    <= phase_d;
      mode_exp_q <= mode_exp_d;
      single_q   <= single_d;
      cascade_q  <= cascade_d;
      rss_q      <= rss_d;
      prev_q     <= prev_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q   <= rd_d;
      vec_q  <= vec_d;
      pend_q <= pend_d;
      spur_q <= spur_d;
      init_q <= init_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, init_q, spur_q, pend_q, vec_q, rd_q};

  // At most one level enters service per request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ($countones(svc_d & ~svc_q) <= 1))
    else $error("more than one in-service bit set by one request");

  // An acknowledge never raises a request bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind == REQ_ACK) |-> ((req_d & ~req_q) == 8'd0))
    else $error("acknowledge raised a request bit");

  // A spurious result carries level seven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && spur_q) |-> (vec_q[2:0] == SPURIOUS_LEVEL))
    else $error("spurious vector without level seven");

  // Initialising flag of a fresh result follows the sequence state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (init_q == (phase_q != PH_IDLE)))
    else $error("initialising flag out of step with sequence");

endmodule

`default_nettype wire

>>> test/programmable_interrupt_controller_test.sv
// Self-checking stream testbench for the eight-line interrupt controller.
`default_nettype none

module programmable_interrupt_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pic_pkg::*;

  // Command words used by the stimulus
  localparam logic [7:0] ICW1_CASCADE_MODE = 8'h11;
  localparam logic [7:0] ICW1_SINGLE_MODE  = 8'h13;
  localparam logic [7:0] ICW1_SINGLE       = 8'h12;
  localparam logic [7:0] OCW2_EOI_CMD      = 8'h20;
  localparam logic [7:0] OCW2_SPECIFIC_EOI = 8'h60;
  localparam logic [7:0] OCW3_READ_IRR     = 8'h0A;
  localparam logic [7:0] OCW3_READ_ISR     = 8'h0B;
  localparam logic [7:0] OCW3_NO_READ      = 8'h08;
  localparam int unsigned RANDOM_REQUESTS  = 650;

  typedef struct packed {
    logic       drain;   // wait until every response is back before offering
    req_type_e  kind;
    logic       port;
    logic [7:0] wdata;
    logic [7:0] lines;
  } pic_request_t;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] vec;
    logic       pending;
    logic       spur;
    logic       init;
  } pic_response_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] write_data, [15:8] request_lines
  logic [2:0]  s_axis_tuser = '0;  // [1:0] req_type, [2] port_sel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // [7:0] read_data, [15:8] vector, [16] int_pending,
                                   // [17] spurious, [18] initialising

  programmable_interrupt_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the controller state
  logic [7:0] irr_shadow      = '0;
  logic [7:0] isr_shadow      = '0;
  logic [7:0] imr_shadow      = '0;
  logic [4:0] base_shadow     = '0;
  phase_e     phase_shadow    = PH_IDLE;
  logic       want_mode_word  = 1'b0;
  logic       single_shadow   = 1'b0;
  logic [7:0] cascade_shadow  = '0;
  logic       read_isr_select = 1'b0;
  logic [7:0] lines_last      = '0;

  pic_request_t  requests_queued[$];
  pic_response_t responses_due[$];
  pic_request_t  offered;
  int            requests_taken = 0;
  int            mismatches = 0;
  int            send_gap = 0;
  int            recv_stall = 0;
  int            hold_off = 0;
  bit            hold_off_done = 1'b0;

  function automatic logic [3:0] first_set(logic [7:0] v);
    for (int i = 0; i < 8; i++) begin
      if (v[i]) return 4'(i);
    end
    return LEVEL_NONE;
  endfunction

  // Highest-priority unmasked request that outranks every in-service level
  function automatic logic [3:0] deliverable_level();
    logic [3:0] lvl;
    lvl = first_set(irr_shadow & ~imr_shadow);
    return (lvl < first_set(isr_shadow)) ? lvl : LEVEL_NONE;
  endfunction

  // Advance the shadow state by one request and return the response it gives
  function automatic pic_response_t controller_response(pic_request_t r);
    pic_response_t o;
    logic [3:0]    lvl;
    o = '0;
    case (r.kind)
      REQ_WRITE: begin
        if (r.port == PORT_CMD) begin
          if (r.wdata[CmdInitBit]) begin
            imr_shadow      = '0;
            read_isr_select = 1'b0;
            want_mode_word  = r.wdata[InitModeBit];
            single_shadow   = r.wdata[InitSnglBit];
            phase_shadow    = PH_VECTOR;
          end else if (r.wdata[Ocw3Bit]) begin
            if (r.wdata[Ocw3RrBit]) read_isr_select = r.wdata[Ocw3RisBit];
          end else if (r.wdata[7:5] == OCW2_NS_EOI) begin
            lvl = first_set(isr_shadow);
            if (lvl != LEVEL_NONE) isr_shadow[lvl[2:0]] = 1'b0;
          end
        end else begin
          case (phase_shadow)
            PH_VECTOR: begin
              base_shadow = r.wdata[7:3];
              if (!single_shadow) phase_shadow = PH_CASCADE;
              else phase_shadow = want_mode_word ? PH_MODE : PH_IDLE;
            end
            PH_CASCADE: begin
              cascade_shadow = r.wdata;
              phase_shadow = want_mode_word ? PH_MODE : PH_IDLE;
            end
            PH_MODE: phase_shadow = PH_IDLE;
            default: imr_shadow = r.wdata;
          endcase
        end
      end
      REQ_READ: begin
        if (r.port == PORT_CMD) o.rd = read_isr_select ? isr_shadow : irr_shadow;
        else o.rd = imr_shadow;
      end
      REQ_ACK: begin
        lvl = deliverable_level();
        if (lvl != LEVEL_NONE) begin
          isr_shadow[lvl[2:0]] = 1'b1;
          irr_shadow[lvl[2:0]] = 1'b0;
          o.vec = {base_shadow, lvl[2:0]};
        end else begin
          o.vec  = {base_shadow, SPURIOUS_LEVEL};
          o.spur = 1'b1;
        end
      end
      default: begin
        irr_shadow = (irr_shadow | (r.lines & ~lines_last)) & r.lines;
        lines_last = r.lines;
      end
    endcase
    o.pending = (deliverable_level() != LEVEL_NONE);
    o.init    = (phase_shadow != PH_IDLE);
    return o;
  endfunction

  function automatic void queue_request(req_type_e kind, logic port, logic [7:0] wdata,
                                        logic [7:0] lines, logic drain = 1'b0);
    pic_request_t r;
    r.drain = drain;
    r.kind  = kind;
    r.port  = port;
    r.wdata = wdata;
    r.lines = lines;
    requests_queued.push_back(r);
  endfunction

  // Mostly short gaps, a few long ones, and whole windows with none
  function automatic int idle_length();
    int p;
    if ((requests_taken / 90) % 3 == 1) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Drive requests from the queue, logging each accepted one with the shadow state
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        responses_due.push_back(controller_response(offered));
        requests_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (requests_queued.size() != 0 &&
                     !(requests_queued[0].drain && responses_due.size() != 0)) begin
          offered = requests_queued.pop_front();
          s_axis_tdata  <= {offered.lines, offered.wdata};
          s_axis_tuser  <= {offered.port, offered.kind};
          s_axis_tvalid <= 1'b1;
          send_gap = idle_length();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random, with one long hold-off to back up the input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else if (!hold_off_done && requests_taken >= 300) begin
        hold_off_done = 1'b1;
        hold_off = 60;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall = idle_length();
      end
    end
  end

  // Compare each accepted result with the oldest outstanding response
  always @(posedge clk_i) begin
    pic_response_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (responses_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = responses_due.pop_front();
        check_field("read_data", want.rd, m_axis_tdata[7:0]);
        check_field("vector", want.vec, m_axis_tdata[15:8]);
        check_field("int_pending", 8'(want.pending), 8'(m_axis_tdata[16]));
        check_field("spurious", 8'(want.spur), 8'(m_axis_tdata[17]));
        check_field("initialising", 8'(want.init), 8'(m_axis_tdata[18]));
      end
    end
  end

  // Build the stimulus, release reset and wait for the controller to drain
  initial begin
    int         directed;
    int         total;
    int         p;
    int         n;
    logic [7:0] icw;
    logic [7:0] lines_now;

    // Reset state, init sequences and priority corner cases
    queue_request(REQ_READ,  PORT_CMD,  8'h00, 8'h00);
    queue_request(REQ_READ,  PORT_DATA, 8'h00, 8'h00);
    queue_request(REQ_ACK,   PORT_CMD,  8'h00, 8'h00);       // spurious out of reset
    queue_request(REQ_WRITE, PORT_CMD,  ICW1_CASCADE_MODE, 8'h00);
    queue_request(REQ_READ,  PORT_DATA, 8'h00, 8'h00);       // read during init
    queue_request(REQ_WRITE, PORT_CMD,  OCW3_READ_ISR, 8'h00); // operation word during init
    queue_request(REQ_WRITE, PORT_DATA, 8'hF8, 8'h00);
    queue_request(REQ_WRITE, PORT_DATA, 8'hFF, 8'h00);       // cascade word
    queue_request(REQ_WRITE, PORT_DATA, 8'h00, 8'h00);       // mode word ends init
    queue_request(REQ_WRITE, PORT_DATA, 8'hFF, 8'h00);       // mask everything
    queue_request(REQ_TICK,  PORT_CMD,  8'h00, 8'hFF);
    queue_request(REQ_ACK,   PORT_CMD,  8'h00, 8'h00);       // all masked
    queue_request(REQ_WRITE, PORT_DATA, 8'h00, 8'h00);
    queue_request(REQ_ACK,   PORT_CMD,  8'h00, 8'h00);       // level zero
    queue_request(REQ_READ,  PORT_CMD,  8'h00, 8'h00);
    queue_request(REQ_ACK,   PORT_CMD,  8'h00, 8'h00);       // outranked by in-service
    queue_request(REQ_WRITE, PORT_CMD,  OCW2_SPECIFIC_EOI, 8'h00);
    queue_request(REQ_WRITE, PORT_CMD,  OCW2_EOI_CMD, 8'h00);
    queue_request(REQ_TICK,  PORT_CMD,  8'h00, 8'h00);       // withdrawn requests are lost
    queue_request(REQ_TICK,  PORT_CMD,  8'h00, 8'h80);
    queue_request(REQ_WRITE, PORT_CMD,  OCW3_READ_IRR, 8'h00);
    queue_request(REQ_READ,  PORT_CMD,  8'h00, 8'h00);
    queue_request(REQ_WRITE, PORT_CMD,  ICW1_SINGLE_MODE, 8'h00);
    queue_request(REQ_WRITE, PORT_DATA, 8'h07, 8'h00);
    queue_request(REQ_WRITE, PORT_DATA, 8'h55, 8'h00);
    queue_request(REQ_ACK,   PORT_CMD,  8'h00, 8'h00);       // level seven
    queue_request(REQ_WRITE, PORT_CMD,  OCW2_EOI_CMD, 8'h00);
    queue_request(REQ_WRITE, PORT_CMD,  OCW2_EOI_CMD, 8'h00); // nothing in service
    queue_request(REQ_WRITE, PORT_CMD,  ICW1_SINGLE, 8'h00);
    queue_request(REQ_WRITE, PORT_DATA, 8'hA8, 8'h00);
    queue_request(REQ_WRITE, PORT_CMD,  OCW3_NO_READ, 8'h00, 1'b1); // after a full drain
    directed = requests_queued.size();

    // Random traffic: mostly request flow with acknowledges and end-of-interrupt, plus reads, writes and init sequences
    lines_now = '0;
    n = 0;
    while (requests_queued.size() < directed + RANDOM_REQUESTS) begin
      p = $urandom_range(0, 99);
      if (p < 38) begin
        if ($urandom_range(0, 3) == 0) lines_now = 8'($urandom);
        else lines_now = lines_now ^ (8'h01 << $urandom_range(0, 7));
        queue_request(REQ_TICK, 1'($urandom), 8'($urandom), lines_now, (n % 150) == 0);
      end else if (p < 58) begin
        queue_request(REQ_ACK, 1'($urandom), 8'($urandom), 8'($urandom), (n % 150) == 0);
      end else if (p < 68) begin
        queue_request(REQ_WRITE, PORT_CMD, OCW2_EOI_CMD | 8'($urandom_range(0, 7)),
                      8'($urandom));
      end else if (p < 76) begin
        queue_request(REQ_READ, 1'($urandom), 8'($urandom), 8'($urandom));
      end else if (p < 81) begin
        queue_request(REQ_WRITE, PORT_CMD, {3'($urandom), 2'b01, 3'($urandom)},
                      8'($urandom));
      end else if (p < 86) begin
        queue_request(REQ_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
      end else if (p < 92) begin
        // Full init sequence with random content, now and then cut short
        icw = {3'($urandom), 1'b1, 4'($urandom)};
        queue_request(REQ_WRITE, PORT_CMD, icw, 8'($urandom));
        queue_request(REQ_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
        if (!icw[InitSnglBit] && $urandom_range(0, 7) != 0)
          queue_request(REQ_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
        if (icw[InitModeBit] && $urandom_range(0, 7) != 0)
          queue_request(REQ_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
        queue_request(REQ_WRITE, PORT_DATA, 8'($urandom_range(0, 3)) << 6, 8'($urandom));
      end else begin
        queue_request(req_type_e'($urandom_range(0, 3)), 1'($urandom), 8'($urandom),
                      8'($urandom));
      end
      n++;
    end
    total = requests_queued.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every response has come back
    while (requests_taken != total || responses_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Abandon a hung run
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/pic_pkg.sv
hw/rtl/programmable_interrupt_controller.sv
test/programmable_interrupt_controller_test.sv
